// ===== hdl/angle_bias_kalman_filter_core_defines.svh =====
// Assertion macros for the angle/bias filter core
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
// implication checked at every rising clock edge, disabled during reset
`define ABK_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, also disabled during reset
`define ABK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/abkf_pkg.sv =====
// ---------------------------------------------------------------------------
// abkf_pkg
// Types and constants for the angle/bias filter core.
// ---------------------------------------------------------------------------
`default_nettype none
package abkf_pkg;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [DATA_W-1:0] ANGLE_NOISE_RST = 32'd1288490;
   localparam logic [DATA_W-1:0] BIAS_NOISE_RST = 32'd3865471;
   localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd3435973837;
   localparam logic [DATA_W-1:0] STEP_TIME_RST = 32'd21474836;
   localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ANGLE_NOISE = 2'd0,
      REG_BIAS_NOISE = 2'd1,
      REG_MEASURE_NOISE = 2'd2,
      REG_STEP_TIME = 2'd3
   } reg_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ANG, ST_P00, ST_P01, ST_P10, ST_DEN, ST_K0, ST_K0W, ST_K1, ST_K1W,
      ST_INNOV, ST_AUPD, ST_BUPD, ST_CAA, ST_CAB, ST_CBA, ST_CBB, ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [31:0] q32_to_q28(input logic [31:0] x);
      logic [32:0] s;
      s = {1'b0, x} + 33'd8;
      return {3'b000, s[32:4]};
   endfunction
endpackage
`default_nettype wire

// ===== hdl/abkf_if.sv =====
// ---------------------------------------------------------------------------
// abkf_if
// Valid/ready channel carrying a generic payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface abkf_if #(parameter int unsigned W = 64) ();
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/abkf_div.sv =====
// ---------------------------------------------------------------------------
// abkf_div
// Restoring divider, one quotient bit per cycle: q = (n + d/2) / d.
// ---------------------------------------------------------------------------
`default_nettype none
module abkf_div import abkf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [62:0] num,
   input  wire logic [32:0] den,
   output logic             done,
   output logic [62:0]      quo
);
   logic [62:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [32:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic [33:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      trial = {r_ff[32:0], q_ff[62]};
      if (start) begin
         q_in = num + {31'd0, den[32:1]};
         r_in = '0;
         d_in = den;
         cnt_in = 6'd62;
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in = {q_ff[61:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         if (cnt_ff == 6'd0) run_in = 1'b0;
         else cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end

   assign done = run_ff && (cnt_ff == 6'd0);
   assign quo = q_in;
endmodule
`default_nettype wire

// ===== hdl/angle_bias_kalman_filter_core.sv =====
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// Two-state angle/gyro-bias filter on one shared multiplier and a serial divider.
// ---------------------------------------------------------------------------
// channel  dir  payload
// req      in   measured_angle[31:0], rate[63:32]
// rsp      out  filtered_angle[31:0], bias_estimate[63:32]
// csr      in   we, index, data
// Per item, two serial divisions form the gains and dominate the run time; the
// other sequencer states use the shared multiplier at most once each. A
// non-positive gain denominator skips both divisions.
// req_ready is low while an item is at work or its result waits on rsp.
// Synchronous reset restores the CSRs, estimates, covariance and state; no clearing pass.
`default_nettype none
`include "angle_bias_kalman_filter_core_defines.svh"
module angle_bias_kalman_filter_core import abkf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   abkf_if.sink                      req,
   abkf_if.source                    rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data
);
   state_type st_ff, st_in;
   logic [31:0] an_ff, bn_ff, mn_ff, dt_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] caa_ff, caa_in, cab_ff, cab_in, cba_ff, cba_in, cbb_ff, cbb_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, meas_ff, meas_in, rate_ff, rate_in;
   logic signed [33:0] e_ff, e_in;
   logic [32:0] den_ff, den_in;
   logic denok_ff, denok_in;
   logic signed [34:0] ma;
   logic signed [33:0] mb;
   logic [5:0] sh;
   logic signed [33:0] mag_a, mag_b;
   logic [67:0] prod, rnd;
   logic signed [65:0] mres;
   logic div_start, div_done;
   logic [62:0] dnum, dquo;
   logic signed [65:0] tmp;
   logic [32:0] qs;

   always_comb begin
      mag_a = ma[34] ? -ma[33:0] : ma[33:0];
      mag_b = mb[33] ? -mb : mb;
      prod = {34'd0, mag_a} * {34'd0, mag_b};
      rnd = (prod + (68'd1 << (sh - 6'd1))) >> sh;
      mres = (ma[34] != mb[33]) ? -$signed(rnd[65:0]) : $signed(rnd[65:0]);
   end

   abkf_div u_div (.clock(clock), .reset(reset), .start(div_start),
      .num(dnum), .den(den_ff), .done(div_done), .quo(dquo));

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req.valid) st_in = ST_ANG;
         ST_ANG: st_in = ST_P00;
         ST_P00: st_in = ST_P01;
         ST_P01: st_in = ST_P10;
         ST_P10: st_in = ST_DEN;
         ST_DEN: st_in = ST_K0;
         ST_K0: st_in = denok_ff ? ST_K0W : ST_INNOV;
         ST_K0W: if (div_done) st_in = ST_K1;
         ST_K1: st_in = ST_K1W;
         ST_K1W: if (div_done) st_in = ST_INNOV;
         ST_INNOV: st_in = ST_AUPD;
         ST_AUPD: st_in = ST_BUPD;
         ST_BUPD: st_in = ST_CAA;
         ST_CAA: st_in = ST_CAB;
         ST_CAB: st_in = ST_CBA;
         ST_CBA: st_in = ST_CBB;
         ST_CBB: st_in = ST_OUT;
         ST_OUT: if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff;
      caa_in = caa_ff; cab_in = cab_ff; cba_in = cba_ff; cbb_in = cbb_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      k0_in = k0_ff; k1_in = k1_ff; meas_in = meas_ff; rate_in = rate_ff;
      e_in = e_ff; den_in = den_ff; denok_in = denok_ff;
      ma = '0; mb = '0; sh = 6'd30;
      div_start = 1'b0; dnum = '0; tmp = '0; qs = '0;
      case (st_ff)
         ST_IDLE: begin
            meas_in = req.data[31:0];
            rate_in = req.data[63:32];
            k0_in = '0; k1_in = '0;
         end
         ST_ANG: begin
            ma = 35'(rate_ff) - 35'(bias_ff); mb = {2'b00, dt_ff}; sh = 6'd32;
            ang_in = sat32(66'(ang_ff) + mres);
         end
         ST_P00: begin
            ma = 35'(cab_ff) + 35'(cba_ff); mb = {2'b00, dt_ff}; sh = 6'd32;
            p00_in = sat32(66'(caa_ff) + 66'(signed'({1'b0, q32_to_q28(an_ff)})) - mres);
            p11_in = sat32(66'(cbb_ff) + 66'(signed'({1'b0, q32_to_q28(bn_ff)})));
         end
         ST_P01: begin
            ma = 35'(cbb_ff); mb = {2'b00, dt_ff}; sh = 6'd32;
            p01_in = sat32(66'(cab_ff) - mres);
         end
         ST_P10: begin
            ma = 35'(cbb_ff); mb = {2'b00, dt_ff}; sh = 6'd32;
            p10_in = sat32(66'(cba_ff) - mres);
         end
         ST_DEN: begin
            tmp = 66'(p00_ff) + 66'(signed'({1'b0, q32_to_q28(mn_ff)}));
            denok_in = !tmp[65] && (tmp != '0);
            den_in = tmp[32:0];
         end
         ST_K0: begin
            div_start = denok_ff;
            dnum = {1'b0, (p00_ff[31] ? 32'(-p00_ff) : 32'(p00_ff)), 30'd0};
         end
         ST_K0W: if (div_done) begin
            qs = (dquo > 63'h1_0000_0000) ? 33'h1_0000_0000 : dquo[32:0];
            k0_in = sat32(p00_ff[31] ? -66'(signed'({1'b0, qs})) : 66'(signed'({1'b0, qs})));
         end
         ST_K1: begin
            div_start = 1'b1;
            dnum = {1'b0, (p10_ff[31] ? 32'(-p10_ff) : 32'(p10_ff)), 30'd0};
         end
         ST_K1W: if (div_done) begin
            qs = (dquo > 63'h1_0000_0000) ? 33'h1_0000_0000 : dquo[32:0];
            k1_in = sat32(p10_ff[31] ? -66'(signed'({1'b0, qs})) : 66'(signed'({1'b0, qs})));
         end
         ST_INNOV: e_in = 34'(meas_ff) - 34'(ang_ff);
         ST_AUPD: begin
            ma = 35'(k0_ff); mb = e_ff;
            ang_in = sat32(66'(ang_ff) + mres);
         end
         ST_BUPD: begin
            ma = 35'(k1_ff); mb = e_ff;
            bias_in = sat32(66'(bias_ff) + mres);
         end
         ST_CAA: begin
            ma = 35'(k0_ff); mb = 34'(p00_ff);
            caa_in = sat32(66'(p00_ff) - mres);
         end
         ST_CAB: begin
            ma = 35'(k0_ff); mb = 34'(p01_ff);
            cab_in = sat32(66'(p01_ff) - mres);
         end
         ST_CBA: begin
            ma = 35'(k1_ff); mb = 34'(p00_ff);
            cba_in = sat32(66'(p10_ff) - mres);
         end
         ST_CBB: begin
            ma = 35'(k1_ff); mb = 34'(p01_ff);
            cbb_in = sat32(66'(p11_ff) - mres);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in; rate_ff <= rate_in;
      p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
      k0_ff <= k0_in; k1_ff <= k1_in; e_ff <= e_in; den_ff <= den_in;
      denok_ff <= denok_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         an_ff <= ANGLE_NOISE_RST; bn_ff <= BIAS_NOISE_RST;
         mn_ff <= MEASURE_NOISE_RST; dt_ff <= STEP_TIME_RST;
         ang_ff <= '0; bias_ff <= '0;
         caa_ff <= ONE_Q28; cab_ff <= '0; cba_ff <= '0; cbb_ff <= ONE_Q28;
      end else begin
         st_ff <= st_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         caa_ff <= caa_in; cab_ff <= cab_in; cba_ff <= cba_in; cbb_ff <= cbb_in;
         if (csr_we) begin
            case (reg_idx_type'(csr_index))
               REG_ANGLE_NOISE: an_ff <= csr_data;
               REG_BIAS_NOISE: bn_ff <= csr_data;
               REG_MEASURE_NOISE: mn_ff <= csr_data;
               REG_STEP_TIME: dt_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign req.ready = (st_ff == ST_IDLE);
   assign rsp.valid = (st_ff == ST_OUT);
   assign rsp.data = {bias_ff, ang_ff};

   `ABK_ASSERT_IMPL(a_excl, clock, reset, rsp.valid, !req.ready)
   `ABK_ASSERT_NEXT(a_start, clock, reset, req.valid && req.ready, st_ff == ST_ANG)
   `ABK_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
endmodule
`default_nettype wire

// ===== bench/angle_bias_kalman_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter_core_tb
// Self-checking bench for the angle/bias filter core. Items are sent on the
// req channel with random gaps. Each accepted item runs through a local
// fixed-point filter model that forms the expected angle and bias. Results
// on rsp are compared in order while rsp_ready stalls at random. Noise and
// step-time registers are swept through defaults, extremes and random values.
// ---------------------------------------------------------------------------
module angle_bias_kalman_filter_core_tb;
   import abkf_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ANGLE_NOISE;
   logic [DATA_W-1:0] csr_data = '0;

   abkf_if #(.W(64)) req_if ();
   abkf_if #(.W(64)) rsp_if ();

   angle_bias_kalman_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // filter state mirrored from accepted items and register writes
   logic [31:0] angle_noise_q, bias_noise_q, meas_noise_q, step_time_q;
   int angle_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
   logic [63:0] expected_q[$];
   int errors = 0;
   int mismatches = 0;
   bit no_gaps = 1'b0;
   bit hold_toggle = 1'b0;

   function automatic int sat32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic bit [63:0] magnitude(input longint a);
      return (a < 0) ? 64'd0 - a : a;
   endfunction

   function automatic longint mul_round(input longint a, input longint b, input int sh);
      bit [63:0] p;
      p = magnitude(a) * magnitude(b);
      p = (p + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint noise_q28(input logic [31:0] x);
      return longint'(({32'd0, x} + 64'd8) >> 4);
   endfunction

   function automatic int gain_q30(input int num, input longint den);
      bit [63:0] n, d, q;
      n = magnitude(num) << 30;
      d = den;
      q = (n + d / 2) / d;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      return sat32(num < 0 ? -longint'(q) : longint'(q));
   endfunction

   function automatic logic [63:0] filter_update(input int meas, input int rate);
      longint dt, den, innov;
      int p00, p01, p10, p11, k0, k1;
      dt = longint'({32'd0, step_time_q});
      angle_q = sat32(longint'(angle_q) + mul_round(longint'(rate) - bias_q, dt, 32));
      p00 = sat32(longint'(caa_q) + noise_q28(angle_noise_q)
                  - mul_round(longint'(cab_q) + cba_q, dt, 32));
      p01 = sat32(longint'(cab_q) - mul_round(cbb_q, dt, 32));
      p10 = sat32(longint'(cba_q) - mul_round(cbb_q, dt, 32));
      p11 = sat32(longint'(cbb_q) + noise_q28(bias_noise_q));
      den = longint'(p00) + noise_q28(meas_noise_q);
      k0 = 0;
      k1 = 0;
      if (den > 0) begin
         k0 = gain_q30(p00, den);
         k1 = gain_q30(p10, den);
      end
      innov = longint'(meas) - angle_q;
      angle_q = sat32(longint'(angle_q) + mul_round(k0, innov, 30));
      bias_q = sat32(longint'(bias_q) + mul_round(k1, innov, 30));
      caa_q = sat32(longint'(p00) - mul_round(k0, p00, 30));
      cab_q = sat32(longint'(p01) - mul_round(k0, p01, 30));
      cba_q = sat32(longint'(p10) - mul_round(k1, p00, 30));
      cbb_q = sat32(longint'(p11) - mul_round(k1, p01, 30));
      return {bias_q[31:0], angle_q[31:0]};
   endfunction

   // model update and result check, all on the rising edge
   always @(posedge clock) begin
      logic [63:0] exp_item;
      if (reset) begin
         angle_noise_q <= ANGLE_NOISE_RST;
         bias_noise_q <= BIAS_NOISE_RST;
         meas_noise_q <= MEASURE_NOISE_RST;
         step_time_q <= STEP_TIME_RST;
         angle_q <= 0;
         bias_q <= 0;
         caa_q <= ONE_Q28;
         cab_q <= 0;
         cba_q <= 0;
         cbb_q <= ONE_Q28;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_q.push_back(filter_update(req_if.data[31:0], req_if.data[63:32]));
         if (csr_we) begin
            case (reg_idx_type'(csr_index))
               REG_ANGLE_NOISE:   angle_noise_q = csr_data;
               REG_BIAS_NOISE:    bias_noise_q = csr_data;
               REG_MEASURE_NOISE: meas_noise_q = csr_data;
               REG_STEP_TIME:     step_time_q = csr_data;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10)
                  $display("unexpected result item %h", rsp_if.data);
            end else begin
               exp_item = expected_q.pop_front();
               if (rsp_if.data[31:0] !== exp_item[31:0] ||
                   rsp_if.data[63:32] !== exp_item[63:32]) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch angle exp %h got %h, bias exp %h got %h",
                              exp_item[31:0], rsp_if.data[31:0],
                              exp_item[63:32], rsp_if.data[63:32]);
               end
            end
         end
      end
   end

   // result-side stalls; a toggle of hold_toggle starts a long hold-off
   always @(negedge clock) begin
      static int stall_left = 0;
      static bit seen_toggle = 1'b0;
      int r;
      if (hold_toggle != seen_toggle) begin
         seen_toggle = hold_toggle;
         stall_left = 400;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (no_gaps || r < 70) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [31:0] meas, input logic [31:0] rate);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {rate, meas};
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_regs(input logic [31:0] an, input logic [31:0] bn,
                             input logic [31:0] mn, input logic [31:0] dt);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= REG_ANGLE_NOISE;
      csr_data <= an;
      @(negedge clock);
      csr_index <= REG_BIAS_NOISE;
      csr_data <= bn;
      @(negedge clock);
      csr_index <= REG_MEASURE_NOISE;
      csr_data <= mn;
      @(negedge clock);
      csr_index <= REG_STEP_TIME;
      csr_data <= dt;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_tracking(input int count);
      int truth, drift, meas, rate;
      truth = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      drift = int'($urandom_range(0, 1 << 18)) - (1 << 17);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            send_item($urandom, $urandom);
         end else begin
            rate = int'($urandom_range(0, 1 << 24)) - (1 << 23);
            truth = truth + (rate >>> 6);
            meas = truth + int'($urandom_range(0, 1 << 16)) - (1 << 15);
            send_item(meas, rate + drift);
         end
      end
   endtask

   task automatic test_directed_defaults();
      logic [31:0] pats[6];
      pats = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'haaaaaaaa, 32'h55555555};
      foreach (pats[i]) send_item(pats[i], 32'h0);
      foreach (pats[i]) send_item(32'h0, pats[i]);
      send_item(32'h7fffffff, 32'h80000000);
      send_item(32'h80000000, 32'h7fffffff);
   endtask

   task automatic test_register_extremes();
      write_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_item(32'h7fffffff, 32'h7fffffff);
      send_item(32'h80000000, 32'h80000000);
      send_item(32'h00010000, 32'hffff0000);
      // zero noise and zero step: variance collapses, gains go to zero
      write_regs(32'h0, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 5; i++) send_item($urandom, $urandom);
      write_regs(32'h0, 32'hffffffff, 32'hffffffff, 32'h0);
      send_item(32'h00050000, 32'h00010000);
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 4; p++) begin
         write_regs($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                    $urandom, $urandom_range(0, 1 << 27));
         send_tracking(60);
      end
      write_regs($urandom, $urandom, $urandom, $urandom);
      send_tracking(40);
   endtask

   task automatic test_backpressure();
      wait_idle();
      no_gaps = 1'b1;
      hold_toggle = ~hold_toggle;
      send_tracking(30);
      no_gaps = 1'b0;
      wait_idle();
      send_tracking(10);
   endtask

   task automatic test_default_tracking();
      write_regs(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST, STEP_TIME_RST);
      send_tracking(400);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_defaults();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      test_default_tracking();
      wait_idle();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/abkf_pkg.sv
hdl/abkf_if.sv
hdl/abkf_div.sv
hdl/angle_bias_kalman_filter_core.sv
bench/angle_bias_kalman_filter_core_tb.sv
